// ----- hw/rtl/wsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

   localparam int unsigned MAX_PAYLOAD = 125;

   localparam logic [7:0] FIN_BIT       = 8'h80;
   localparam logic [7:0] OPCODE_MASK   = 8'h0f;
   localparam logic [7:0] LENGTH_MASK   = 8'h7f;
   localparam logic [3:0] OPCODE_BINARY = 4'h2;
   localparam int unsigned KEY_BYTES    = 4;

   typedef enum logic [1:0] {
      KIND_DATA       = 2'd0,
      KIND_EMPTY      = 2'd1,
      KIND_BAD_FRAME  = 2'd2,
      KIND_BAD_OPCODE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_HDR0   = 3'd0,
      PH_HDR1   = 3'd1,
      PH_MASK   = 3'd2,
      PH_DATA   = 3'd3,
      PH_CLOSED = 3'd4
   } phase_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } result_type;

endpackage

// ----- hw/rtl/websocket_frame_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Streaming parser for short, masked, binary WebSocket frames.
// ----------------------------------------------------------------------------
// One received byte enters per transfer on the req_ side, and a new byte is
// taken every cycle while the result register is free or being drained. A byte
// is held in the input register until the result register can take its result,
// then passes the parser logic and lands in the result register, which drives
// the rsp_ side. Header and mask bytes of a frame that passes the header check
// give no result, except the last mask byte of a zero-length frame (kind 1,
// tlast high); the mask bytes are kept as the key. Payload bytes are
// unmasked and forwarded as they arrive, tlast on the final byte. A header that
// fails the check gives kind 2 (not FIN, reserved bits, length over 125, or
// unmasked) or kind 3 (opcode not binary); after either the block drops every
// byte until reset. rsp_tuser carries the kind.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast
);
   import wsd_pkg::*;

   // input register: holds one byte until the parser can take it
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;

   logic       out_free;
   logic       advance;
   result_type result;

   // advance the held byte only when the result register can take its result
   assign advance    = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in = in_vld_ff && !advance;
      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   wsd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .result  (result)
   );

   wsd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a held byte that cannot advance stays held
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !out_free |=> in_vld_ff && $stable(in_byte_ff))
      else $error("held input byte lost while result register busy");

   // only payload results carry data; errors never carry tlast
   a_result_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_DATA
      |-> rsp_tdata == 8'd0 && rsp_tlast == (rsp_tuser == KIND_EMPTY))
      else $error("malformed non-payload result");

endmodule

// ----- hw/rtl/wsd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_core
// Frame parser: header check, mask capture and payload unmasking.
// ----------------------------------------------------------------------------
module wsd_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         in_byte,
   output wsd_pkg::result_type result
);
   import wsd_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] first_header_ff, first_header_in;
   logic [7:0] mask_key_ff [KEY_BYTES];
   logic [1:0] mask_index_ff, mask_index_in;
   logic [6:0] remaining_ff, remaining_in;
   logic       key_we;

   logic [6:0] len;
   logic       bad_frame;
   logic       bad_opcode;
   logic [6:0] rem_dec;

   assign len        = in_byte[6:0] & LENGTH_MASK[6:0];
   assign bad_frame  = ((first_header_ff & ~OPCODE_MASK) != FIN_BIT)
                       || (len > 7'(MAX_PAYLOAD)) || !in_byte[7];
   assign bad_opcode = (first_header_ff[3:0] & OPCODE_MASK[3:0]) != OPCODE_BINARY;
   assign rem_dec    = (remaining_ff != 7'd0) ? remaining_ff - 7'd1 : 7'd0;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_HDR0: phase_in = PH_HDR1;
         PH_HDR1: begin
            if (bad_frame || bad_opcode) begin
               phase_in = PH_CLOSED;
            end else begin
               phase_in = PH_MASK;
            end
         end
         PH_MASK: begin
            if (mask_index_ff == 2'd3) begin
               phase_in = (remaining_ff == 7'd0) ? PH_HDR0 : PH_DATA;
            end
         end
         PH_DATA: begin
            if (rem_dec == 7'd0) begin
               phase_in = PH_HDR0;
            end
         end
         PH_CLOSED: phase_in = PH_CLOSED;
         default:   phase_in = PH_CLOSED;
      endcase
   end

   // results and data-path updates
   always_comb begin
      first_header_in = first_header_ff;
      mask_index_in   = mask_index_ff;
      remaining_in    = remaining_ff;
      key_we          = 1'b0;
      result          = '{valid: 1'b0, kind: KIND_DATA, data: 8'd0, last: 1'b0};
      case (phase_ff)
         PH_HDR0: first_header_in = in_byte;
         PH_HDR1: begin
            if (bad_frame) begin
               result.valid = 1'b1;
               result.kind  = KIND_BAD_FRAME;
            end else if (bad_opcode) begin
               result.valid = 1'b1;
               result.kind  = KIND_BAD_OPCODE;
            end else begin
               remaining_in  = len;
               mask_index_in = 2'd0;
            end
         end
         PH_MASK: begin
            key_we        = 1'b1;
            mask_index_in = mask_index_ff + 2'd1;
            if (mask_index_ff == 2'd3 && remaining_ff == 7'd0) begin
               result.valid = 1'b1;
               result.kind  = KIND_EMPTY;
               result.last  = 1'b1;
            end
         end
         PH_DATA: begin
            remaining_in  = rem_dec;
            mask_index_in = (rem_dec == 7'd0) ? 2'd0 : mask_index_ff + 2'd1;
            result.valid  = 1'b1;
            result.kind   = KIND_DATA;
            result.data   = in_byte ^ mask_key_ff[mask_index_ff];
            result.last   = (rem_dec == 7'd0);
         end
         PH_CLOSED: ;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR0;
         first_header_ff <= 8'd0;
         mask_index_ff   <= 2'd0;
         remaining_ff    <= 7'd0;
         for (int i = 0; i < KEY_BYTES; i++) begin
            mask_key_ff[i] <= 8'd0;
         end
      end else if (step) begin
         phase_ff        <= phase_in;
         first_header_ff <= first_header_in;
         mask_index_ff   <= mask_index_in;
         remaining_ff    <= remaining_in;
         if (key_we) begin
            mask_key_ff[mask_index_ff] <= in_byte;
         end
      end
   end

   // once closed, stay closed until reset
   a_closed_sticks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CLOSED |=> phase_ff == PH_CLOSED)
      else $error("closed parser reopened");

   // payload phase always has bytes left to take
   a_data_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> remaining_ff != 7'd0)
      else $error("payload phase with zero bytes remaining");

   // an error result always closes the parser
   a_error_closes: assert property (@(posedge clock) disable iff (reset)
      step && result.valid
      && (result.kind == KIND_BAD_FRAME || result.kind == KIND_BAD_OPCODE)
      |=> phase_ff == PH_CLOSED)
      else $error("error result without closing");

endmodule

// ----- hw/rtl/wsd_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register with stream handshake toward the consumer.
// ----------------------------------------------------------------------------
module wsd_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  wsd_pkg::result_type result,
   output logic               free,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic [1:0]         rsp_tuser,
   output logic               rsp_tlast
);
   import wsd_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   kind_type   kind_ff;
   logic       last_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      if (load) begin
         valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         data_ff <= result.data;
         kind_ff <= result.kind;
         last_ff <= result.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule
